// ===== sv/lrc_pkg.sv =====
// Shared types, fixed-point constants and band codes for the log rainbow colormap.
package lrc_pkg;

  localparam int VALUE_BITS_DEF      = 32;
  localparam int VALUE_FRAC_BITS_DEF = 16;

  // Q1.30 mantissa, Q28 logarithm
  localparam int MANT_FRAC = 30;
  localparam int MANT_W    = MANT_FRAC + 1;
  localparam int LOG_FRAC  = 28;
  localparam int BIAS_W    = 7;
  localparam int ILOG_W    = 35;
  localparam int CH_W      = 8;
  localparam int BAND_W    = 3;

  localparam logic [LOG_FRAC-1:0] LN2_Q28  = 28'd186065280;
  localparam logic [ILOG_W-1:0]   K_Q28    = 35'd10460014286;
  // K plus nine units: top edge of the ramp range
  localparam logic [ILOG_W-1:0]   TOP_Q28  = 35'd12875933390;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
  localparam logic [CH_W-1:0] CH_MIN = 8'h00;
  localparam logic [CH_W-1:0] CH_SCALE = 8'd255;

  localparam logic [BAND_W-1:0] BAND_BELOW = 3'd0;
  localparam logic [BAND_W-1:0] BAND_RAMP1 = 3'd1;
  localparam logic [BAND_W-1:0] BAND_RAMP2 = 3'd2;
  localparam logic [BAND_W-1:0] BAND_RAMP3 = 3'd3;
  localparam logic [BAND_W-1:0] BAND_RAMP4 = 3'd4;
  localparam logic [BAND_W-1:0] BAND_RAMP5 = 3'd5;
  localparam logic [BAND_W-1:0] BAND_ABOVE = 3'd6;

  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [ILOG_W-1:0] ilog;
  } lrc_ctl_t;

endpackage

// ===== sv/log_rainbow_colormap.sv =====
// Top level: pipelined logarithmic rainbow colormap, one magnitude in and one RGB pixel out.
// One pixel per clock: a magnitude taken with start gives its pixel on red/green/blue/band
// with done high for one cycle, in order. The latency is set by the log2 fraction, which
// takes 28 pipelined squaring stages of the Q1.30 mantissa, plus the leading-one search,
// mantissa shift, ln scaling, classification and ramp stages. busy is high only during
// reset, and the block never holds done off: the receiver takes every beat.
module log_rainbow_colormap #(
  parameter int VALUE_BITS      = lrc_pkg::VALUE_BITS_DEF,
  parameter int VALUE_FRAC_BITS = lrc_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_BITS-1:0]         magnitude,
  output logic                          busy,
  output logic                          done,
  output logic [lrc_pkg::CH_W-1:0]      red,
  output logic [lrc_pkg::CH_W-1:0]      green,
  output logic [lrc_pkg::CH_W-1:0]      blue,
  output logic [lrc_pkg::BAND_W-1:0]    band
);

  localparam int LF      = lrc_pkg::LOG_FRAC;
  localparam int LATENCY = LF + 6;

  logic                  in_valid;
  logic [VALUE_BITS-1:0] mag;

  logic [lrc_pkg::MANT_W-1:0] x_s    [0:LF];
  logic [LF-1:0]              frac_s [0:LF];
  lrc_pkg::lrc_ctl_t          ctl_s  [0:LF];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    mag <= magnitude;
  end

  lrc_norm #(
    .VALUE_BITS      (VALUE_BITS),
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .value    (mag),
    .x        (x_s[0]),
    .ctl      (ctl_s[0])
  );

  assign frac_s[0] = '0;

  for (genvar i = 0; i < LF; i++) begin : g_sq
    lrc_sq_stage u_sq (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_s[i]),
      .x_in     (x_s[i]),
      .frac_in  (frac_s[i]),
      .ctl_out  (ctl_s[i+1]),
      .x_out    (x_s[i+1]),
      .frac_out (frac_s[i+1])
    );
  end

  lrc_color u_color (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_s[LF]),
    .frac_in (frac_s[LF]),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .band    (band)
  );

  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat did not produce a result at the expected latency");

  // no result without a beat accepted at the matching cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result strobe without an accepted beat");

  a_below_blue: assert property (@(posedge clk) disable iff (rst)
    (done && band == lrc_pkg::BAND_BELOW) |->
      (red == lrc_pkg::CH_MIN && green == lrc_pkg::CH_MIN && blue == lrc_pkg::CH_MAX))
    else $error("below-range pixel is not blue");

  a_above_magenta: assert property (@(posedge clk) disable iff (rst)
    (done && band == lrc_pkg::BAND_ABOVE) |->
      (red == lrc_pkg::CH_MAX && green == lrc_pkg::CH_MIN && blue == lrc_pkg::CH_MAX))
    else $error("above-range pixel is not magenta");

  a_band2_green: assert property (@(posedge clk) disable iff (rst)
    (done && band == lrc_pkg::BAND_RAMP2) |->
      (red == lrc_pkg::CH_MIN && green == lrc_pkg::CH_MAX))
    else $error("cyan-to-green band lost full green");

endmodule

// ===== sv/lrc_norm.sv =====
// Leading-one search and mantissa normalization, exponent part of ln (biased by 64) scaled in Q28.
module lrc_norm #(
  parameter int VALUE_BITS      = lrc_pkg::VALUE_BITS_DEF,
  parameter int VALUE_FRAC_BITS = lrc_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [VALUE_BITS-1:0]         value,
  output logic [lrc_pkg::MANT_W-1:0]    x,
  output lrc_pkg::lrc_ctl_t             ctl
);

  localparam int P_W   = $clog2(VALUE_BITS);
  localparam int EXT_W = VALUE_BITS + lrc_pkg::MANT_W;

  logic                  valid1;
  logic                  zero1;
  logic [P_W-1:0]        p1;
  logic [VALUE_BITS-1:0] v1;
  logic [P_W-1:0]        p_next;

  logic [P_W-1:0]                  shamt;
  logic [VALUE_BITS-1:0]           norm;
  logic [EXT_W-1:0]                ext;
  logic [lrc_pkg::BIAS_W:0]        bias;
  logic [lrc_pkg::ILOG_W-1:0]      ilog_next;

  always_comb begin
    p_next = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (value[i]) begin
        p_next = P_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    zero1 <= (value == '0);
    p1    <= p_next;
    v1    <= value;
  end

  // left-justify the value, keep the top bits as Q1.30
  assign shamt = P_W'(VALUE_BITS - 1) - p1;
  assign norm  = v1 << shamt;
  assign ext   = {norm, {lrc_pkg::MANT_W{1'b0}}};
  assign bias  = (lrc_pkg::BIAS_W + 1)'(p1) + (lrc_pkg::BIAS_W + 1)'(64 - VALUE_FRAC_BITS);
  assign ilog_next = lrc_pkg::ILOG_W'(bias[lrc_pkg::BIAS_W-1:0])
                   * lrc_pkg::ILOG_W'(lrc_pkg::LN2_Q28);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= valid1;
    end
    ctl.zero <= zero1;
    ctl.ilog <= ilog_next;
    x        <= ext[EXT_W-1 -: lrc_pkg::MANT_W];
  end

endmodule

// ===== sv/lrc_sq_stage.sv =====
// One squaring step of the log2 fraction: square the mantissa, emit one fraction bit.
module lrc_sq_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  lrc_pkg::lrc_ctl_t             ctl_in,
  input  logic [lrc_pkg::MANT_W-1:0]    x_in,
  input  logic [lrc_pkg::LOG_FRAC-1:0]  frac_in,
  output lrc_pkg::lrc_ctl_t             ctl_out,
  output logic [lrc_pkg::MANT_W-1:0]    x_out,
  output logic [lrc_pkg::LOG_FRAC-1:0]  frac_out
);

  localparam int SQ_W = 2 * lrc_pkg::MANT_W;

  logic [SQ_W-1:0]              sq;
  logic [lrc_pkg::MANT_W:0]     t;
  logic                         bit_next;
  logic [lrc_pkg::MANT_W-1:0]   x_next;

  assign sq       = SQ_W'(x_in) * SQ_W'(x_in);
  assign t        = sq[SQ_W-1:lrc_pkg::MANT_FRAC];
  assign bit_next = t[lrc_pkg::MANT_W];
  // square reached [2,4): halve it back into [1,2)
  assign x_next   = bit_next ? t[lrc_pkg::MANT_W:1] : t[lrc_pkg::MANT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.zero <= ctl_in.zero;
    ctl_out.ilog <= ctl_in.ilog;
    x_out        <= x_next;
    frac_out     <= {frac_in[lrc_pkg::LOG_FRAC-2:0], bit_next};
  end

endmodule

// ===== sv/lrc_color.sv =====
// Natural log assembly, range and band classification, channel ramps and result register.
module lrc_color (
  input  logic                          clk,
  input  logic                          rst,
  input  lrc_pkg::lrc_ctl_t             ctl_in,
  input  logic [lrc_pkg::LOG_FRAC-1:0]  frac_in,
  output logic                          done,
  output logic [lrc_pkg::CH_W-1:0]      red,
  output logic [lrc_pkg::CH_W-1:0]      green,
  output logic [lrc_pkg::CH_W-1:0]      blue,
  output logic [lrc_pkg::BAND_W-1:0]    band
);

  localparam int LF     = lrc_pkg::LOG_FRAC;
  localparam int FP_W   = 2 * LF;
  localparam int REM_W  = LF + 1;
  localparam int SPAN_W = LF + 2;
  localparam int RP_W   = SPAN_W + lrc_pkg::CH_W;

  // stage A: fractional part of ln
  logic [FP_W-1:0]      fprod;
  lrc_pkg::lrc_ctl_t    ctl_a;
  logic [LF-1:0]        fr_a;

  // stage B: classify
  logic [lrc_pkg::ILOG_W-1:0] n;
  logic [lrc_pkg::ILOG_W-1:0] s;
  logic                       below;
  logic                       above;
  logic [lrc_pkg::BAND_W-1:0] band_next;
  logic                       valid_b;
  logic [lrc_pkg::BAND_W-1:0] band_b;
  logic [REM_W-1:0]           rem_b;

  // stage C: ramps
  logic [RP_W-1:0]            up_full;
  logic [RP_W-1:0]            down_full;
  logic [lrc_pkg::CH_W-1:0]   up;
  logic [lrc_pkg::CH_W-1:0]   down;
  logic [lrc_pkg::CH_W-1:0]   red_next;
  logic [lrc_pkg::CH_W-1:0]   green_next;
  logic [lrc_pkg::CH_W-1:0]   blue_next;

  assign fprod = FP_W'(frac_in) * FP_W'(lrc_pkg::LN2_Q28);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else begin
      ctl_a.valid <= ctl_in.valid;
    end
    ctl_a.zero <= ctl_in.zero;
    ctl_a.ilog <= ctl_in.ilog;
    fr_a       <= fprod[FP_W-1:LF];
  end

  assign n     = ctl_a.ilog + lrc_pkg::ILOG_W'(fr_a);
  assign below = ctl_a.zero || (n <= lrc_pkg::K_Q28);
  assign above = (n > lrc_pkg::TOP_Q28);
  assign s     = n - lrc_pkg::K_Q28;

  always_comb begin
    if (below) begin
      band_next = lrc_pkg::BAND_BELOW;
    end else if (above) begin
      band_next = lrc_pkg::BAND_ABOVE;
    end else begin
      band_next = s[LF+3:LF+1] + lrc_pkg::BAND_RAMP1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= ctl_a.valid;
    end
    band_b <= band_next;
    rem_b  <= s[LF:0];
  end

  assign up_full   = RP_W'(rem_b) * RP_W'(lrc_pkg::CH_SCALE);
  assign down_full = (RP_W'(1) << (LF + 1)) - RP_W'(rem_b);
  assign up        = up_full[LF+lrc_pkg::CH_W:LF+1];
  assign down      = lrc_pkg::CH_W'((down_full * RP_W'(lrc_pkg::CH_SCALE)) >> (LF + 1));

  always_comb begin
    case (band_b)
      lrc_pkg::BAND_BELOW: begin
        red_next = lrc_pkg::CH_MIN; green_next = lrc_pkg::CH_MIN; blue_next = lrc_pkg::CH_MAX;
      end
      lrc_pkg::BAND_RAMP1: begin
        red_next = lrc_pkg::CH_MIN; green_next = up;             blue_next = lrc_pkg::CH_MAX;
      end
      lrc_pkg::BAND_RAMP2: begin
        red_next = lrc_pkg::CH_MIN; green_next = lrc_pkg::CH_MAX; blue_next = down;
      end
      lrc_pkg::BAND_RAMP3: begin
        red_next = up;             green_next = lrc_pkg::CH_MAX; blue_next = lrc_pkg::CH_MIN;
      end
      lrc_pkg::BAND_RAMP4: begin
        red_next = lrc_pkg::CH_MAX; green_next = down;           blue_next = lrc_pkg::CH_MIN;
      end
      lrc_pkg::BAND_RAMP5: begin
        red_next = lrc_pkg::CH_MAX; green_next = lrc_pkg::CH_MIN; blue_next = up;
      end
      lrc_pkg::BAND_ABOVE: begin
        red_next = lrc_pkg::CH_MAX; green_next = lrc_pkg::CH_MIN; blue_next = lrc_pkg::CH_MAX;
      end
      default: begin
        red_next = lrc_pkg::CH_MIN; green_next = lrc_pkg::CH_MIN; blue_next = lrc_pkg::CH_MIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_b;
    end
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
    band  <= band_b;
  end

endmodule
